/* design/swb_rng_pkg.sv */
// ----------------------------------------------------------------------------
// Subtract-with-borrow generator package
// Lags, counter widths, seeding constants, the initial-value ROM and the
// types shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package swb_rng_pkg;

  localparam int LONG_LAG      = 48;
  localparam int SHORT_LAG     = 8;
  localparam int WARMUP_PASSES = 6;

  localparam int IDX_W         = $clog2(LONG_LAG);
  localparam int DISCARD_STEPS = 3;
  localparam int WARMUP_DRAWS  = LONG_LAG * WARMUP_PASSES;

  localparam int CNT_MAX_A = (WARMUP_DRAWS > LONG_LAG) ? WARMUP_DRAWS : LONG_LAG;
  localparam int CNT_MAX   = (CNT_MAX_A > DISCARD_STEPS) ? CNT_MAX_A : DISCARD_STEPS;
  localparam int CNT_W     = $clog2(CNT_MAX + 1);

  localparam int VALUE_W = 31;
  localparam int WORD_W  = 32;

  localparam logic [IDX_W-1:0] TAP_START =
      (SHORT_LAG < LONG_LAG) ? IDX_W'(LONG_LAG - SHORT_LAG) : '0;

  localparam logic [WORD_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [WORD_W-1:0] LCG_ADD = 32'd12345;

  localparam int ROM_WORDS = 48;
  localparam int ROM_AW    = $clog2(ROM_WORDS);

  localparam logic [WORD_W-1:0] INIT_ROM [ROM_WORDS] = '{
    32'd1947146662, 32'd255872804,  32'd611859725,  32'd1698768494,
    32'd1168331706, 32'd903266320,  32'd156960988,  32'd2108094856,
    32'd1962943837, 32'd190733878,  32'd1611490366, 32'd1064800627,
    32'd750133665,  32'd1388252873, 32'd1292226713, 32'd2024731946,
    32'd1741633152, 32'd1048965367, 32'd1242081949, 32'd648944060,
    32'd2146570054, 32'd1918590288, 32'd1154878382, 32'd1659238901,
    32'd1517088874, 32'd1343505038, 32'd702442230,  32'd223319626,
    32'd2112415214, 32'd1198445789, 32'd1667134997, 32'd81636584,
    32'd1477696870, 32'd1396665379, 32'd296474908,  32'd221800638,
    32'd285530547,  32'd506210295,  32'd322166150,  32'd242833116,
    32'd542659480,  32'd1371231536, 32'd164404762,  32'd580757470,
    32'd1564914124, 32'd2004579430, 32'd389459662,  32'd1039937051
  };

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW_EX,
    ST_SEED_MIX,
    ST_SEED_FILL,
    ST_WARM_RD,
    ST_WARM_EX
  } state_e;

  typedef struct packed {
    logic seed_load;
    logic lcg_step;
    logic fill_wr;
    idx_t fill_addr;
    logic rd;
    logic ex;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  // Table entries past the end of the ROM are seeded with the plain LCG value.
  function automatic logic [WORD_W-1:0] rom_word(input idx_t idx);
    logic [ROM_AW-1:0] a;
    logic [WORD_W-1:0] w;
    a = ROM_AW'(idx);
    w = '0;
    if (int'(idx) < ROM_WORDS) begin
      w = INIT_ROM[a];
    end
    return w;
  endfunction

  function automatic idx_t next_idx(input idx_t i);
    idx_t n;
    n = i + idx_t'(1);
    if (i == idx_t'(LONG_LAG - 1)) begin
      n = '0;
    end
    return n;
  endfunction

endpackage

/* design/swb_rng_ctrl.sv */
// ----------------------------------------------------------------------------
// Subtract-with-borrow generator controller
// Sequences draws, the reseed LCG mixing and fill, and the warm-up draws.
// ----------------------------------------------------------------------------
module swb_rng_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  swb_rng_pkg::dp_status_t sts_i,
  output swb_rng_pkg::ctl_cmd_t   cmd_o
);

  swb_rng_pkg::state_e                state_q, state_d;
  logic [swb_rng_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                               accept;
  logic                               mix_last, fill_last, warm_last;

  assign accept    = (state_q == swb_rng_pkg::ST_IDLE) && in_valid_i;
  assign mix_last  = (cnt_q == swb_rng_pkg::CNT_W'(swb_rng_pkg::DISCARD_STEPS - 1));
  assign fill_last = (cnt_q == swb_rng_pkg::CNT_W'(swb_rng_pkg::LONG_LAG - 1));
  assign warm_last = (cnt_q == swb_rng_pkg::CNT_W'(swb_rng_pkg::WARMUP_DRAWS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swb_rng_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = mode_i ? swb_rng_pkg::ST_SEED_MIX : swb_rng_pkg::ST_DRAW_EX;
        end
      end
      swb_rng_pkg::ST_DRAW_EX: begin
        if (!sts_i.out_busy) begin
          state_d = swb_rng_pkg::ST_IDLE;
        end
      end
      swb_rng_pkg::ST_SEED_MIX: begin
        if (mix_last) begin
          state_d = swb_rng_pkg::ST_SEED_FILL;
        end
      end
      swb_rng_pkg::ST_SEED_FILL: begin
        if (fill_last) begin
          state_d = (swb_rng_pkg::WARMUP_DRAWS == 0) ? swb_rng_pkg::ST_IDLE
                                                     : swb_rng_pkg::ST_WARM_RD;
        end
      end
      swb_rng_pkg::ST_WARM_RD: begin
        state_d = swb_rng_pkg::ST_WARM_EX;
      end
      swb_rng_pkg::ST_WARM_EX: begin
        state_d = warm_last ? swb_rng_pkg::ST_IDLE : swb_rng_pkg::ST_WARM_RD;
      end
      default: begin
        state_d = swb_rng_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      swb_rng_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          // A draw reads both table entries at the accepting edge.
          cmd_o.seed_load = mode_i;
          cmd_o.rd        = !mode_i;
        end
      end
      swb_rng_pkg::ST_DRAW_EX: begin
        cmd_o.ex       = !sts_i.out_busy;
        cmd_o.out_load = !sts_i.out_busy;
      end
      swb_rng_pkg::ST_SEED_MIX: begin
        cmd_o.lcg_step = 1'b1;
      end
      swb_rng_pkg::ST_SEED_FILL: begin
        cmd_o.lcg_step  = 1'b1;
        cmd_o.fill_wr   = 1'b1;
        cmd_o.fill_addr = cnt_q[swb_rng_pkg::IDX_W-1:0];
      end
      swb_rng_pkg::ST_WARM_RD: begin
        cmd_o.rd = 1'b1;
      end
      swb_rng_pkg::ST_WARM_EX: begin
        cmd_o.ex = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    case (state_q)
      swb_rng_pkg::ST_SEED_MIX:  cnt_d = mix_last  ? '0 : cnt_q + swb_rng_pkg::CNT_W'(1);
      swb_rng_pkg::ST_SEED_FILL: cnt_d = fill_last ? '0 : cnt_q + swb_rng_pkg::CNT_W'(1);
      swb_rng_pkg::ST_WARM_EX:   cnt_d = warm_last ? '0 : cnt_q + swb_rng_pkg::CNT_W'(1);
      swb_rng_pkg::ST_WARM_RD:   cnt_d = cnt_q;
      default:                   cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swb_rng_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* design/swb_rng_dp.sv */
// ----------------------------------------------------------------------------
// Subtract-with-borrow generator datapath
// Lag table memory, indices, borrow, seeding LCG and the result register.
// ----------------------------------------------------------------------------
module swb_rng_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  swb_rng_pkg::ctl_cmd_t                 cmd_i,
  output swb_rng_pkg::dp_status_t               sts_o,
  input  logic [swb_rng_pkg::WORD_W-1:0]        seed_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [swb_rng_pkg::VALUE_W-1:0]       value_o
);

  logic [swb_rng_pkg::WORD_W-1:0]   mem [swb_rng_pkg::LONG_LAG];
  logic [swb_rng_pkg::LONG_LAG-1:0] vld_q;

  swb_rng_pkg::idx_t                feed_q, tap_q;
  logic                             borrow_q;
  logic [swb_rng_pkg::WORD_W-1:0]   lcg_q, lcg_nxt;
  logic [swb_rng_pkg::WORD_W-1:0]   tap_rd_q, feed_rd_q;
  logic                             tap_ok_q, feed_ok_q;
  logic [swb_rng_pkg::WORD_W-1:0]   tap_word, feed_word, diff;
  logic                             out_valid_q;
  logic [swb_rng_pkg::VALUE_W-1:0]  value_q;

  logic                             wr_en;
  swb_rng_pkg::idx_t                wr_addr;
  logic [swb_rng_pkg::WORD_W-1:0]   wr_data;

  assign lcg_nxt = lcg_q * swb_rng_pkg::LCG_MUL + swb_rng_pkg::LCG_ADD;

  // Entries not written since reset read as zero.
  assign tap_word  = tap_ok_q  ? tap_rd_q  : '0;
  assign feed_word = feed_ok_q ? feed_rd_q : '0;
  assign diff      = tap_word - feed_word - {{(swb_rng_pkg::WORD_W-1){1'b0}}, borrow_q};

  assign wr_en   = cmd_i.fill_wr || cmd_i.ex;
  assign wr_addr = cmd_i.fill_wr ? cmd_i.fill_addr : feed_q;
  assign wr_data = cmd_i.fill_wr ? (lcg_nxt ^ swb_rng_pkg::rom_word(cmd_i.fill_addr))
                                 : {1'b0, diff[swb_rng_pkg::VALUE_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      tap_rd_q  <= mem[tap_q];
      feed_rd_q <= mem[feed_q];
      tap_ok_q  <= vld_q[tap_q];
      feed_ok_q <= vld_q[feed_q];
    end
    if (cmd_i.seed_load) begin
      lcg_q <= seed_i;
    end else if (cmd_i.lcg_step) begin
      lcg_q <= lcg_nxt;
    end
    if (cmd_i.out_load) begin
      value_q <= diff[swb_rng_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      feed_q      <= '0;
      tap_q       <= swb_rng_pkg::TAP_START;
      borrow_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.seed_load) begin
        feed_q   <= '0;
        tap_q    <= swb_rng_pkg::TAP_START;
        borrow_q <= 1'b0;
      end else if (cmd_i.ex) begin
        feed_q   <= swb_rng_pkg::next_idx(feed_q);
        tap_q    <= swb_rng_pkg::next_idx(tap_q);
        borrow_q <= diff[swb_rng_pkg::WORD_W-1];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;

endmodule

/* design/subtract_with_borrow_rng_unit.sv */
// ----------------------------------------------------------------------------
// Subtract-with-borrow random number generator
// Lags 48 and 8, modulus 2^31, with LCG-based reseeding and warm-up draws.
// ----------------------------------------------------------------------------
// Draw: the lag table is read into registers when the request is taken, and
// the result register loads in DRAW_EX once the output is not stalled; no
// new request is taken before that load. Reseed: one LCG step per cycle
// through the mix and fill, then each warm-up draw a read then an execute
// state. No result. Reset sets the indices to their start, clears borrow and
// per-entry valid flags, so the table reads as all zero right after reset.
module subtract_with_borrow_rng_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic [swb_rng_pkg::WORD_W-1:0]      seed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [swb_rng_pkg::VALUE_W-1:0]     value_o
);

  swb_rng_pkg::ctl_cmd_t   cmd;
  swb_rng_pkg::dp_status_t sts;

  swb_rng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swb_rng_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .seed_i      (seed_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

  // The single write port is never shared between a fill and a draw update.
  a_wr_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fill_wr |-> !cmd.ex && !cmd.rd)
    else $error("fill write collides with a draw");

  // A taken request keeps the block busy in the following cycle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one still in progress");

  // A held result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  // A reseed request never produces a result in the next cycle.
  a_reseed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i |=> !cmd.out_load && !cmd.rd)
    else $error("reseed started a draw");

endmodule
